@@ src/jdsp_pkg.sv @@
// Shared types, constants and the sequencer program for the JTAG DR scan packer.
// No dependencies; used by jdsp_packer, jtag_dr_scan_packer_unit and jdsp_checker.
package jdsp_pkg;

  // Batch geometry
  localparam int BATCH_WORDS    = 256;
  localparam int SLOTS_PER_WORD = 4;
  localparam int SLOT_CAP       = SLOTS_PER_WORD * BATCH_WORDS;
  localparam int CNT_W          = $clog2(SLOT_CAP + 1);
  localparam int SLOTS_OUT_W    = 11;
  // count register is never narrower than the reported field
  localparam int SLOT_W         = (CNT_W > SLOTS_OUT_W) ? CNT_W : SLOTS_OUT_W;

  // Field widths
  localparam int WORD_W  = 12;
  localparam int VALUE_W = 64;
  localparam int LEN_W   = 7;
  localparam int MAX_LEN = 64;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 24;

  // Program counter and step addresses
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_SELECT  = 3'd0;
  localparam pc_t STEP_CAPTURE = 3'd1;
  localparam pc_t STEP_SHIFT   = 3'd2;
  localparam pc_t STEP_DATA    = 3'd3;
  localparam pc_t STEP_UPDATE  = 3'd4;
  localparam pc_t STEP_IDLE    = 3'd5;
  localparam pc_t STEP_CLOSE   = 3'd6;
  localparam pc_t STEP_END     = 3'd7;

  typedef enum logic [1:0] {OP_TCK, OP_CLOSE, OP_FINISH} op_t;
  typedef enum logic [1:0] {TMS_ZERO, TMS_ONE, TMS_LAST} tms_sel_t;
  typedef enum logic [1:0] {BR_NEXT, BR_LOOP, BR_IF_OPEN} br_t;

  // One control word per step
  typedef struct packed {
    op_t      op;
    tms_sel_t tms_sel;
    logic     tdi_data;  // 1: TDI from the data shifter, 0: TDI low
    br_t      br;
    pc_t      target;    // jump address for BR_IF_OPEN
  } ucode_t;

  // Slot command from the sequencer to the packer
  typedef struct packed {
    logic valid;
    logic close;  // 1: terminator slot and batch close
    logic tms;
    logic tdi;
  } slot_cmd_t;

  // Word produced by the packer
  typedef struct packed {
    logic                   valid;
    logic [WORD_W-1:0]      word;
    logic [SLOTS_OUT_W-1:0] slots;
    logic                   ovf;
  } word_t;

  // Sequencer program: TAP path Select-DR, Capture-DR, Shift-DR, data bits,
  // Update-DR, Run-Test-Idle, optional close, finish.
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t cw;
    cw = '{op: OP_FINISH, tms_sel: TMS_ZERO, tdi_data: 1'b0, br: BR_NEXT, target: STEP_END};
    case (pc)
      STEP_SELECT:  cw = '{OP_TCK, TMS_ONE, 1'b0, BR_NEXT, STEP_END};
      STEP_CAPTURE: cw = '{OP_TCK, TMS_ZERO, 1'b0, BR_NEXT, STEP_END};
      STEP_SHIFT:   cw = '{OP_TCK, TMS_ZERO, 1'b0, BR_NEXT, STEP_END};
      STEP_DATA:    cw = '{OP_TCK, TMS_LAST, 1'b1, BR_LOOP, STEP_END};
      STEP_UPDATE:  cw = '{OP_TCK, TMS_ONE, 1'b0, BR_NEXT, STEP_END};
      STEP_IDLE:    cw = '{OP_TCK, TMS_ZERO, 1'b0, BR_IF_OPEN, STEP_END};
      STEP_CLOSE:   cw = '{OP_CLOSE, TMS_ZERO, 1'b0, BR_NEXT, STEP_END};
      STEP_END:     cw = '{OP_FINISH, TMS_ZERO, 1'b0, BR_NEXT, STEP_END};
      default:      cw = '{OP_FINISH, TMS_ZERO, 1'b0, BR_NEXT, STEP_END};
    endcase
    return cw;
  endfunction

endpackage

@@ src/jdsp_packer.sv @@
// Slot packer: turns each TCK command into a slot pair, packs four slots per word,
// tracks the batch slot count and overflow. Depends on jdsp_pkg.
module jdsp_packer (
  input  logic               clk,
  input  logic               rst,
  input  jdsp_pkg::slot_cmd_t cmd,
  output jdsp_pkg::word_t    emit
);

  logic [jdsp_pkg::WORD_W-1:0] partial_word, partial_word_next;
  logic [jdsp_pkg::SLOT_W-1:0] slot_count, slot_count_next;
  logic                        overflow_flag, overflow_flag_next;

  logic                        room;
  logic [jdsp_pkg::WORD_W-1:0] pair_word;

  // Count is always even between TCK commands, so a pair lands at slot 0 or 2
  assign room = slot_count < jdsp_pkg::SLOT_W'(jdsp_pkg::SLOT_CAP);

  always_comb begin
    pair_word = partial_word;
    if (!slot_count[1]) begin
      pair_word[1:0]  = {2{cmd.tdi}};
      pair_word[5:4]  = {2{cmd.tms}};
      pair_word[9:8]  = 2'b10;
    end else begin
      pair_word[3:2]   = {2{cmd.tdi}};
      pair_word[7:6]   = {2{cmd.tms}};
      pair_word[11:10] = 2'b10;
    end
  end

  // Next state and word emission
  always_comb begin
    partial_word_next  = partial_word;
    slot_count_next    = slot_count;
    overflow_flag_next = overflow_flag;
    emit               = '0;
    if (cmd.valid) begin
      if (cmd.close) begin
        // one zero slot fits when there is room; a full batch drops it and sets overflow
        emit.valid = 1'b1;
        emit.word  = partial_word;
        emit.slots = room ? slot_count[jdsp_pkg::SLOTS_OUT_W-1:0] + 1'b1
                          : slot_count[jdsp_pkg::SLOTS_OUT_W-1:0];
        emit.ovf   = overflow_flag | !room;
        partial_word_next  = '0;
        slot_count_next    = '0;
        overflow_flag_next = 1'b0;
      end else if (room) begin
        slot_count_next = slot_count + jdsp_pkg::SLOT_W'(2);
        if (slot_count[1]) begin
          emit.valid        = 1'b1;
          emit.word         = pair_word;
          emit.ovf          = overflow_flag;
          partial_word_next = '0;
        end else begin
          partial_word_next = pair_word;
        end
      end else begin
        overflow_flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word  <= '0;
      slot_count    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      partial_word  <= partial_word_next;
      slot_count    <= slot_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule

@@ src/jtag_dr_scan_packer_unit.sv @@
// JTAG DR scan packer top level: microcoded sequencer, one-word hold stage and
// output register. Depends on jdsp_pkg and jdsp_packer.
//
// One scan request is taken at a time. Once it is accepted, the sequencer runs
// one program step per clock, each TCK step giving two slots: 3 steps
// into Shift-DR, clamped scan_length data steps, 2 steps back to Run-Test-Idle, one
// close step when tlast is set, and one finish step. The next request is
// accepted only after the finish step. Steps pause while the output word is
// held by the sink. One word is held back until it is known whether it ends
// the request's run.
module jtag_dr_scan_packer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [jdsp_pkg::IN_W-1:0]  s_axis_tdata,  // scan_value[63:0], scan_length[70:64], zero
  input  logic                       s_axis_tlast,  // close_batch
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [jdsp_pkg::OUT_W-1:0] m_axis_tdata,  // packed_word[11:0], batch_slots[22:12], zero
  output logic                       m_axis_tlast,  // word_last
  output logic                       m_axis_tuser   // batch_overflow
);

  // Sequencer registers
  logic                         busy;
  jdsp_pkg::pc_t                pc;
  logic [jdsp_pkg::VALUE_W-1:0] value;
  logic [jdsp_pkg::LEN_W-1:0]   remaining;
  logic                         close_req;

  // Hold stage and output register
  logic                         hold_valid;
  jdsp_pkg::word_t              hold;

  jdsp_pkg::ucode_t             cw;
  jdsp_pkg::slot_cmd_t          cmd;
  jdsp_pkg::word_t              emit;
  logic                         out_free;
  logic                         step;
  logic                         last_bit;
  logic [jdsp_pkg::LEN_W-1:0]   in_len, len_clamped;

  assign s_axis_tready = !busy;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = busy && out_free;
  assign cw            = jdsp_pkg::ucode(pc);
  assign last_bit      = remaining == jdsp_pkg::LEN_W'(1);

  // Length clamp to 1..64
  assign in_len = s_axis_tdata[jdsp_pkg::VALUE_W +: jdsp_pkg::LEN_W];
  always_comb begin
    len_clamped = in_len;
    if (in_len == '0)
      len_clamped = jdsp_pkg::LEN_W'(1);
    else if (in_len > jdsp_pkg::LEN_W'(jdsp_pkg::MAX_LEN))
      len_clamped = jdsp_pkg::LEN_W'(jdsp_pkg::MAX_LEN);
  end

  // Slot command decoded from the control word
  always_comb begin
    cmd.valid = step && (cw.op == jdsp_pkg::OP_TCK || cw.op == jdsp_pkg::OP_CLOSE);
    cmd.close = cw.op == jdsp_pkg::OP_CLOSE;
    cmd.tdi   = cw.tdi_data ? value[0] : 1'b0;
    case (cw.tms_sel)
      jdsp_pkg::TMS_ZERO: cmd.tms = 1'b0;
      jdsp_pkg::TMS_ONE:  cmd.tms = 1'b1;
      jdsp_pkg::TMS_LAST: cmd.tms = last_bit;
      default:            cmd.tms = 1'b0;
    endcase
  end

  jdsp_packer u_packer (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .emit (emit)
  );

  // Step counter, data shifter and branch handling
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= jdsp_pkg::STEP_SELECT;
    end else if (!busy) begin
      if (s_axis_tvalid) begin
        busy      <= 1'b1;
        pc        <= jdsp_pkg::STEP_SELECT;
        value     <= s_axis_tdata[jdsp_pkg::VALUE_W-1:0];
        remaining <= len_clamped;
        close_req <= s_axis_tlast;
      end
    end else if (step) begin
      if (cw.op == jdsp_pkg::OP_FINISH) begin
        busy <= 1'b0;
      end else begin
        case (cw.br)
          jdsp_pkg::BR_LOOP: begin
            value     <= value >> 1;
            remaining <= remaining - 1'b1;
            if (last_bit)
              pc <= pc + 1'b1;
          end
          jdsp_pkg::BR_IF_OPEN: begin
            pc <= close_req ? pc + 1'b1 : cw.target;
          end
          default: begin
            pc <= pc + 1'b1;
          end
        endcase
      end
    end
  end

  // Hold one word back until the next word or the end of the run is known
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (step && (emit.valid || cw.op == jdsp_pkg::OP_FINISH) && hold_valid) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {1'b0, hold.slots, hold.word};
        m_axis_tlast  <= !emit.valid;  // finish step ends the run
        m_axis_tuser  <= hold.ovf;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (step && emit.valid) begin
        hold       <= emit;
        hold_valid <= 1'b1;
      end else if (step && cw.op == jdsp_pkg::OP_FINISH) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/jdsp_checker.sv @@
// Port-level checker for the JTAG DR scan packer and its bind statement.
// Depends on jtag_dr_scan_packer_unit and jdsp_pkg.
module jdsp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [jdsp_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [jdsp_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       m_axis_tuser
);

  // stalled output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // one request at a time: no acceptance right after an acceptance
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in progress");

  // slot count only appears on a word that ends a run
  a_slots_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[22:12] == '0)
    else $error("slot count on a word that is not last");

  // nothing is offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind jtag_dr_scan_packer_unit jdsp_checker u_jdsp_checker (.*);
